// ----- design/assert_macros.svh -----
// assertion macros used by the decoder back end
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PGRD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PGRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pgrd_pkg.sv -----
// shared types and constants of the pk glyph run decoder
// no dependencies
package pgrd_pkg;

    localparam int ROW_W        = 64;
    localparam int CFG_W        = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int MAX_WIDTH    = 64;
    localparam int MAX_HEIGHT   = 64;
    localparam int RUN_BITS_DEF = 13;
    localparam int CMDQ_DEPTH   = 2;
    localparam int ROWQ_DEPTH   = 4;

    localparam logic [3:0] RAW_PARAM = 4'd14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLYPH_WIDTH  = 2'd0,
        CFG_GLYPH_HEIGHT = 2'd1,
        CFG_RUN_PARAM    = 2'd2,
        CFG_START_BLACK  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [6:0] width;
        logic [6:0] height;
        logic [3:0] param;
        logic       start_black;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       raster;
    } t_cmd;

    typedef struct packed {
        logic [ROW_W-1:0] pixels;
        logic [5:0]       number;
        logic [5:0]       copies;
        logic             done;
        logic             last;
    } t_row;

endpackage

// ----- design/pk_glyph_run_decoder.sv -----
// pk glyph run decoder top level: configuration registers, front queue, sequencer, row queue
// flow: a byte is stored in the front queue and taken by the sequencer when it is idle;
// a finished row waits in the sequencer's hold register and then in the row queue; the
// sequencer works a packed byte nybble by nybble and run segment by run segment, a raster
// byte bit by bit; a full row queue can stall the sequencer while it stays full
// reset: synchronous active low, clears queues and decode state, width and height 1
module pk_glyph_run_decoder #(
    parameter int RUN_BITS = pgrd_pkg::RUN_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      i_packet_byte,
    input  logic                            i_first_of_glyph,
    output logic                            empty,
    input  logic                            pop,
    output logic [pgrd_pkg::ROW_W-1:0]      o_row_pixels,
    output logic [5:0]                      o_row_number,
    output logic [5:0]                      o_copies_after,
    output logic                            o_glyph_done,
    output logic                            o_last_of_batch,
    input  logic                            i_cfg_we,
    input  logic [pgrd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pgrd_pkg::CFG_W-1:0]      i_cfg_data
);

    pgrd_pkg::t_cfg r_cfg, n_cfg;
    logic           cmd_valid;
    pgrd_pkg::t_cmd cmd;
    logic           cmd_take;
    logic           row_push;
    pgrd_pkg::t_row row_in;
    logic           row_ready;
    pgrd_pkg::t_row row_out;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                pgrd_pkg::CFG_GLYPH_WIDTH:  n_cfg.width       = i_cfg_data;
                pgrd_pkg::CFG_GLYPH_HEIGHT: n_cfg.height      = i_cfg_data;
                pgrd_pkg::CFG_RUN_PARAM:    n_cfg.param       = i_cfg_data[3:0];
                pgrd_pkg::CFG_START_BLACK:  n_cfg.start_black = i_cfg_data[0];
                default:                    n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width       <= 7'd1;
            r_cfg.height      <= 7'd1;
            r_cfg.param       <= 4'd0;
            r_cfg.start_black <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    pgrd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_packet_byte    (i_packet_byte),
        .i_first_of_glyph (i_first_of_glyph),
        .i_run_param      (r_cfg.param),
        .o_full           (full),
        .o_cmd_valid      (cmd_valid),
        .o_cmd            (cmd),
        .i_cmd_take       (cmd_take)
    );

    pgrd_back #(
        .RUN_BITS (RUN_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_row_push  (row_push),
        .o_row       (row_in),
        .i_row_ready (row_ready)
    );

    pgrd_rowq u_rowq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (row_push),
        .i_row   (row_in),
        .o_ready (row_ready),
        .o_empty (empty),
        .i_pop   (pop),
        .o_row   (row_out)
    );

    assign o_row_pixels    = row_out.pixels;
    assign o_row_number    = row_out.number;
    assign o_copies_after  = row_out.copies;
    assign o_glyph_done    = row_out.done;
    assign o_last_of_batch = row_out.last;

endmodule

// ----- design/pgrd_front.sv -----
// front end: accepts packet bytes, tags the decode mode and queues them
// depends on pgrd_pkg
module pgrd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [7:0]        i_packet_byte,
    input  logic              i_first_of_glyph,
    input  logic [3:0]        i_run_param,
    output logic              o_full,
    output logic              o_cmd_valid,
    output pgrd_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_take
);

    localparam int PTR_W = (pgrd_pkg::CMDQ_DEPTH > 1) ? $clog2(pgrd_pkg::CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(pgrd_pkg::CMDQ_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(pgrd_pkg::CMDQ_DEPTH - 1);

    pgrd_pkg::t_cmd   r_mem [pgrd_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             push_ok;
    logic             pop_ok;
    pgrd_pkg::t_cmd   new_cmd;

    assign o_full      = (r_cnt == CNT_W'(pgrd_pkg::CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rd];
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = i_cmd_take && o_cmd_valid;

    always_comb begin
        new_cmd.data   = i_packet_byte;
        new_cmd.first  = i_first_of_glyph;
        new_cmd.raster = (i_run_param == pgrd_pkg::RAW_PARAM);
    end

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
        end
        if (pop_ok) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
        end
        priority if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - CNT_W'(1);
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= new_cmd;
        end
    end

endmodule

// ----- design/pgrd_rowq.sv -----
// result queue holding finished rows until they are popped
// depends on pgrd_pkg
module pgrd_rowq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pgrd_pkg::t_row i_row,
    output logic           o_ready,
    output logic           o_empty,
    input  logic           i_pop,
    output pgrd_pkg::t_row o_row
);

    localparam int PTR_W = (pgrd_pkg::ROWQ_DEPTH > 1) ? $clog2(pgrd_pkg::ROWQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(pgrd_pkg::ROWQ_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(pgrd_pkg::ROWQ_DEPTH - 1);

    pgrd_pkg::t_row   r_mem [pgrd_pkg::ROWQ_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_ready = (r_cnt != CNT_W'(pgrd_pkg::ROWQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_row   = r_mem[r_rd];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        if (push_ok) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
        end
        if (pop_ok) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
        end
        priority if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - CNT_W'(1);
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_row;
        end
    end

endmodule

// ----- design/pgrd_back.sv -----
// back end: decode sequencer for packed runs and raw raster bits, builds rows
// depends on pgrd_pkg and assert_macros.svh
`include "assert_macros.svh"

module pgrd_back #(
    parameter int RUN_BITS = pgrd_pkg::RUN_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pgrd_pkg::t_cfg i_cfg,
    input  logic           i_cmd_valid,
    input  pgrd_pkg::t_cmd i_cmd,
    output logic           o_cmd_take,
    output logic           o_row_push,
    output pgrd_pkg::t_row o_row,
    input  logic           i_row_ready
);

    localparam int ROW_W = pgrd_pkg::ROW_W;
    localparam int W_SUM = RUN_BITS + 5;
    localparam int LONG_BIAS = 193;
    localparam int LONG_STEP = 15;
    localparam logic [RUN_BITS-1:0] RUN_MAX = '1;
    localparam logic [ROW_W-1:0] ALL_ONES = '1;
    localparam logic [ROW_W-1:0] LEFT_BIT = {1'b1, {(ROW_W-1){1'b0}}};
    localparam logic [3:0] NYB_REPEAT = 4'd14;
    localparam logic [3:0] NYB_REPEAT_ONE = 4'd15;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [3:0] MAX_ZEROS = 4'd15;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_NYB  = 5'b00010,
        S_RUN  = 5'b00100,
        S_RAST = 5'b01000,
        S_END  = 5'b10000
    } t_state;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_SECOND = 4'b0010,
        PH_ZEROS  = 4'b0100,
        PH_DIGITS = 4'b1000
    } t_phase;

    function automatic logic [6:0] clamp_dim(input logic [6:0] v, input logic [6:0] lim);
        logic [6:0] r;
        if (v == 7'd0) begin
            r = 7'd1;
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [RUN_BITS-1:0] sat_run(input logic [W_SUM-1:0] v);
        return (v > W_SUM'(RUN_MAX)) ? RUN_MAX : v[RUN_BITS-1:0];
    endfunction

    t_state             r_state, n_state;
    logic [7:0]         r_data, n_data;
    logic               r_nyb_sel, n_nyb_sel;
    logic [3:0]         r_bit_idx, n_bit_idx;
    logic [ROW_W-1:0]   r_buf, n_buf;
    logic [6:0]         r_col, n_col;
    logic [6:0]         r_row, n_row;
    logic [RUN_BITS-1:0] r_run, n_run;
    logic               r_colour, n_colour;
    logic [RUN_BITS-1:0] r_repeat, n_repeat;
    t_phase             r_phase, n_phase;
    logic [3:0]         r_digits, n_digits;
    logic [RUN_BITS-1:0] r_accum, n_accum;
    logic               r_rep_pend, n_rep_pend;
    logic               r_finished, n_finished;
    pgrd_pkg::t_row     r_hold, n_hold;
    logic               r_hold_vld, n_hold_vld;

    logic [6:0]          w;
    logic [6:0]          h;
    logic [3:0]          nyb;
    logic [3:0]          d;
    logic [RUN_BITS-1:0] second_val;
    logic [RUN_BITS-1:0] digits_acc;
    logic [W_SUM-1:0]    long_v;
    logic [W_SUM-1:0]    long_sub;
    logic [RUN_BITS-1:0] long_val;
    logic [3:0]          digits_dec;
    logic [6:0]          room;
    logic [6:0]          take;
    logic [6:0]          col_end;
    logic [ROW_W-1:0]    run_buf;
    logic [ROW_W-1:0]    rast_buf;
    logic [2:0]          bit_pos;
    logic [6:0]          avail;
    logic [6:0]          copies;
    logic [6:0]          row_next;
    logic                fin_next;
    logic                emit_ok;
    logic                emit;
    logic [ROW_W-1:0]    emit_buf;
    logic                adv;
    logic                num_done;
    logic [RUN_BITS-1:0] num_val;
    t_state              adv_state;

    assign w   = clamp_dim(i_cfg.width, 7'(pgrd_pkg::MAX_WIDTH));
    assign h   = clamp_dim(i_cfg.height, 7'(pgrd_pkg::MAX_HEIGHT));
    assign d   = i_cfg.param;
    assign nyb = r_nyb_sel ? r_data[3:0] : r_data[7:4];

    // number assembly
    assign second_val = sat_run(W_SUM'({r_accum, 4'b0000}) + W_SUM'(nyb) + W_SUM'(d)
                                + W_SUM'(1));
    assign digits_acc = sat_run(W_SUM'({r_accum, 4'b0000}) + W_SUM'(nyb));
    assign long_v     = W_SUM'(digits_acc) + W_SUM'(LONG_BIAS);
    assign long_sub   = W_SUM'(d) * W_SUM'(LONG_STEP);
    assign long_val   = sat_run((long_v > long_sub) ? long_v - long_sub : '0);
    assign digits_dec = (r_digits == 4'd0) ? 4'd0 : r_digits - 4'd1;

    // one run segment per cycle, unless a finished row cannot be handed on
    assign room    = (r_col < w) ? w - r_col : 7'd0;
    assign take    = (r_run < RUN_BITS'(room)) ? r_run[6:0] : room;
    assign col_end = r_col + take;
    assign run_buf = r_colour ? (r_buf | ((ALL_ONES >> r_col) & ~(ALL_ONES >> col_end)))
                              : r_buf;

    // one raster bit per cycle, paused while a finished row is handed on or cannot leave
    assign bit_pos  = 3'd7 - r_bit_idx[2:0];
    assign rast_buf = r_data[bit_pos] ? (r_buf | (LEFT_BIT >> r_col)) : r_buf;

    // row bookkeeping for an ending row
    assign avail    = (r_row < h) ? h - 7'd1 - r_row : 7'd0;
    assign copies   = (r_repeat < RUN_BITS'(avail)) ? r_repeat[6:0] : avail;
    assign row_next = r_row + 7'd1 + copies;
    assign fin_next = (row_next >= h);
    assign emit_ok  = !r_hold_vld || i_row_ready;

    assign adv_state = r_nyb_sel ? S_END : S_NYB;

    always_comb begin
        n_state    = r_state;
        n_data     = r_data;
        n_nyb_sel  = r_nyb_sel;
        n_bit_idx  = r_bit_idx;
        n_buf      = r_buf;
        n_col      = r_col;
        n_row      = r_row;
        n_run      = r_run;
        n_colour   = r_colour;
        n_repeat   = r_repeat;
        n_phase    = r_phase;
        n_digits   = r_digits;
        n_accum    = r_accum;
        n_rep_pend = r_rep_pend;
        n_finished = r_finished;
        n_hold     = r_hold;
        n_hold_vld = r_hold_vld;
        o_cmd_take = 1'b0;
        o_row_push = 1'b0;
        o_row      = r_hold;
        o_row.last = (r_state == S_END);
        emit       = 1'b0;
        emit_buf   = r_buf;
        adv        = 1'b0;
        num_done   = 1'b0;
        num_val    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    n_data     = i_cmd.data;
                    n_nyb_sel  = 1'b0;
                    n_bit_idx  = 4'd0;
                    n_state    = i_cmd.raster ? S_RAST : S_NYB;
                    if (i_cmd.first) begin
                        n_buf      = '0;
                        n_col      = '0;
                        n_row      = '0;
                        n_run      = '0;
                        n_colour   = i_cfg.start_black;
                        n_repeat   = '0;
                        n_phase    = PH_IDLE;
                        n_digits   = '0;
                        n_accum    = '0;
                        n_rep_pend = 1'b0;
                        n_finished = 1'b0;
                    end
                end
            end
            S_NYB: begin
                if (r_finished) begin
                    adv = 1'b1;
                end else begin
                    unique case (r_phase)
                        PH_IDLE: begin
                            priority if (nyb == NYB_REPEAT) begin
                                n_rep_pend = 1'b1;
                                adv        = 1'b1;
                            end else if (nyb == NYB_REPEAT_ONE) begin
                                n_repeat   = RUN_BITS'(1);
                                n_rep_pend = 1'b0;
                                adv        = 1'b1;
                            end else if (nyb == 4'd0) begin
                                n_phase  = PH_ZEROS;
                                n_digits = 4'd1;
                                adv      = 1'b1;
                            end else if (nyb > d) begin
                                n_accum = RUN_BITS'(nyb - d - 4'd1);
                                n_phase = PH_SECOND;
                                adv     = 1'b1;
                            end else begin
                                num_done = 1'b1;
                                num_val  = RUN_BITS'(nyb);
                            end
                        end
                        PH_SECOND: begin
                            n_phase  = PH_IDLE;
                            num_done = 1'b1;
                            num_val  = second_val;
                        end
                        PH_ZEROS: begin
                            if (nyb == 4'd0) begin
                                if (r_digits < MAX_ZEROS) begin
                                    n_digits = r_digits + 4'd1;
                                end
                            end else begin
                                n_accum = RUN_BITS'(nyb);
                                n_phase = PH_DIGITS;
                            end
                            adv = 1'b1;
                        end
                        PH_DIGITS: begin
                            n_accum  = digits_acc;
                            n_digits = digits_dec;
                            if (digits_dec == 4'd0) begin
                                n_phase  = PH_IDLE;
                                num_done = 1'b1;
                                num_val  = long_val;
                            end else begin
                                adv = 1'b1;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            adv     = 1'b1;
                        end
                    endcase
                end
                if (num_done) begin
                    if (r_rep_pend) begin
                        n_repeat   = num_val;
                        n_rep_pend = 1'b0;
                        adv        = 1'b1;
                    end else begin
                        n_run   = num_val;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (r_run == '0 || r_finished) begin
                    n_colour = ~r_colour;
                    n_run    = '0;
                    adv      = 1'b1;
                end else if (col_end >= w && !emit_ok) begin
                    n_run = r_run;
                end else begin
                    n_buf = run_buf;
                    n_col = col_end;
                    n_run = r_run - RUN_BITS'(take);
                    if (col_end >= w) begin
                        emit     = 1'b1;
                        emit_buf = run_buf;
                    end
                end
            end
            S_RAST: begin
                if (r_finished || (r_bit_idx == BITS_PER_BYTE && r_col < w)) begin
                    n_state = S_END;
                end else if (r_col >= w) begin
                    if (emit_ok) begin
                        emit     = 1'b1;
                        emit_buf = r_buf;
                    end
                end else begin
                    n_buf     = rast_buf;
                    n_col     = r_col + 7'd1;
                    n_bit_idx = r_bit_idx + 4'd1;
                end
            end
            S_END: begin
                if (!r_hold_vld) begin
                    n_state = S_IDLE;
                end else if (i_row_ready) begin
                    o_row_push = 1'b1;
                    n_hold_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (adv) begin
            n_nyb_sel = 1'b1;
            n_state   = adv_state;
        end

        // the previous row leaves as soon as a newer one exists
        if (emit) begin
            o_row_push     = r_hold_vld;
            n_hold.pixels  = emit_buf;
            n_hold.number  = r_row[5:0];
            n_hold.copies  = copies[5:0];
            n_hold.done    = fin_next;
            n_hold.last    = 1'b0;
            n_hold_vld     = 1'b1;
            n_row          = row_next;
            n_finished     = fin_next;
            n_buf          = '0;
            n_col          = '0;
            n_repeat       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_nyb_sel  <= 1'b0;
            r_bit_idx  <= '0;
            r_buf      <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_run      <= '0;
            r_colour   <= 1'b0;
            r_repeat   <= '0;
            r_phase    <= PH_IDLE;
            r_digits   <= '0;
            r_accum    <= '0;
            r_rep_pend <= 1'b0;
            r_finished <= 1'b0;
            r_hold_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_nyb_sel  <= n_nyb_sel;
            r_bit_idx  <= n_bit_idx;
            r_buf      <= n_buf;
            r_col      <= n_col;
            r_row      <= n_row;
            r_run      <= n_run;
            r_colour   <= n_colour;
            r_repeat   <= n_repeat;
            r_phase    <= n_phase;
            r_digits   <= n_digits;
            r_accum    <= n_accum;
            r_rep_pend <= n_rep_pend;
            r_finished <= n_finished;
            r_hold_vld <= n_hold_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_hold <= n_hold;
    end

    `PGRD_ASSERT_IMPLY(a_push_room, i_clk, i_rst_n, o_row_push, i_row_ready, "row request into full queue")
    `PGRD_ASSERT_IMPLY(a_no_row_after_done, i_clk, i_rst_n, emit, !r_finished, "row built after glyph end")
    `PGRD_ASSERT_IMPLY(a_col_range, i_clk, i_rst_n, r_state != S_IDLE, r_col <= 7'(ROW_W), "column past row")
    `PGRD_ASSERT_NEXT(a_end_flush, i_clk, i_rst_n, r_state == S_END && i_row_ready, !r_hold_vld && r_state == S_IDLE, "held row not flushed")

endmodule
